### hw/rtl/configurable_bit_serial_crc_unit_defines.svh
// ----------------------------------------------------------------------------
// crc unit assertion macros
// concurrent assertion shorthands, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef CONFIGURABLE_BIT_SERIAL_CRC_UNIT_DEFINES_SVH
`define CONFIGURABLE_BIT_SERIAL_CRC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds, consequent holds in the next cycle
`define CBSCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc unit assertion failed");
// antecedent holds, consequent holds in the same cycle
`define CBSCU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc unit assertion failed");
`else
`define CBSCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define CBSCU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/cbscu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscu_pkg
// shared types, register codes and reset values of the bit-serial crc unit
// ----------------------------------------------------------------------------
package cbscu_pkg;

    localparam int MAX_WIDTH_DEF = 32;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 4;
    localparam int CRC_W         = 32;
    localparam int CFG_W         = 32;
    localparam int PW_W          = 6;
    localparam int CFG_IDX_W     = 4;

    localparam logic [CNT_W-1:0] BITS_PER_BYTE = CNT_W'(BYTE_W);

    // register reset values
    localparam logic [CFG_W-1:0] POLY_RST  = 32'h04C1_1DB7;
    localparam int               PW_RST    = 32;
    localparam logic [CFG_W-1:0] INIT_RST  = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0] OXOR_RST  = 32'hFFFF_FFFF;
    localparam logic             REFIN_RST  = 1'b1;
    localparam logic             REFOUT_RST = 1'b1;
    localparam logic             AUG_RST    = 1'b0;
    localparam logic             DIRECT_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLY    = 4'd0,
        REG_WIDTH   = 4'd1,
        REG_INIT    = 4'd2,
        REG_OXOR    = 4'd3,
        REG_REFIN   = 4'd4,
        REG_REFOUT  = 4'd5,
        REG_AUGMENT = 4'd6,
        REG_DIRECT  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] polynomial;
        logic [PW_W-1:0]  poly_width;
        logic [CFG_W-1:0] initial_value;
        logic [CFG_W-1:0] output_xor;
        logic             reflect_input;
        logic             reflect_output;
        logic             zero_augment;
        logic             direct_mode;
    } t_cfg;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_BYTE,
        SRC_ZERO
    } t_bit_src;

    // controller to datapath
    typedef struct packed {
        logic     take_byte;
        logic     shift;
        t_bit_src src;
        logic     finish;
        logic     reload;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/cbscu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscu_ctrl
// sequencer: message bits, zero augmentation and result hand-off
// ----------------------------------------------------------------------------
module cbscu_ctrl #(
    parameter int MAX_WIDTH = cbscu_pkg::MAX_WIDTH_DEF,
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [cbscu_pkg::CNT_W-1:0] i_count,
    input  logic                        i_last,
    input  logic                        i_zero_aug,
    input  logic [WW-1:0]               i_eff_w,
    input  logic                        i_cfg_reload,
    input  cbscu_pkg::t_sts             i_sts,
    output logic                        o_ready,
    output cbscu_pkg::t_cmd             o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MSG,
        S_AUG,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic                        r_ready;
    logic                        r_last;
    logic [cbscu_pkg::CNT_W-1:0] r_cnt;
    logic [WW-1:0]               r_aug;

    logic                        w_accept;
    logic [cbscu_pkg::CNT_W-1:0] w_cnt;

    always_comb begin
        w_accept = i_valid && o_ready;
        w_cnt    = (i_count > cbscu_pkg::BITS_PER_BYTE) ? cbscu_pkg::BITS_PER_BYTE : i_count;

        o_cmd.take_byte = w_accept;
        o_cmd.shift     = (w_accept && (w_cnt != '0)) || (r_state == S_MSG)
                          || (r_state == S_AUG);
        o_cmd.src       = (r_state == S_MSG) ? cbscu_pkg::SRC_BYTE :
                          (r_state == S_AUG) ? cbscu_pkg::SRC_ZERO : cbscu_pkg::SRC_INPUT;
        o_cmd.finish    = (r_state == S_FIN) && i_sts.out_free;
        o_cmd.reload    = i_cfg_reload;
    end

    // closed while a register write reloads the shift register
    assign o_ready = r_ready && !i_cfg_reload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_last  <= 1'b0;
            r_cnt   <= '0;
            r_aug   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_last;
                        if (w_cnt > cbscu_pkg::CNT_W'(1)) begin
                            // first bit went in with the transfer
                            r_state <= S_MSG;
                            r_cnt   <= w_cnt - cbscu_pkg::CNT_W'(1);
                            r_ready <= 1'b0;
                        end else if (i_last) begin
                            r_ready <= 1'b0;
                            if (i_zero_aug) begin
                                r_state <= S_AUG;
                                r_aug   <= i_eff_w;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_MSG: begin
                    r_cnt <= r_cnt - cbscu_pkg::CNT_W'(1);
                    if (r_cnt == cbscu_pkg::CNT_W'(1)) begin
                        if (r_last) begin
                            if (i_zero_aug) begin
                                r_state <= S_AUG;
                                r_aug   <= i_eff_w;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_state <= S_IDLE;
                            r_ready <= 1'b1;
                        end
                    end
                end
                S_AUG: begin
                    r_aug <= r_aug - WW'(1);
                    if (r_aug == WW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

### hw/rtl/cbscu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscu_dp
// crc shift register, byte shifter, finishing logic and output register
// ----------------------------------------------------------------------------
module cbscu_dp #(
    parameter int MAX_WIDTH = cbscu_pkg::MAX_WIDTH_DEF,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int IW = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cbscu_pkg::t_cfg              i_cfg,
    input  logic [WW-1:0]                i_eff_w,
    input  cbscu_pkg::t_cmd              i_cmd,
    input  logic [cbscu_pkg::BYTE_W-1:0] i_data_byte,
    output cbscu_pkg::t_sts              o_sts,
    output logic                         o_crc_valid,
    input  logic                         i_crc_ready,
    output logic [cbscu_pkg::CRC_W-1:0]  o_crc
);

    localparam int RST_W = (cbscu_pkg::PW_RST > MAX_WIDTH) ? MAX_WIDTH : cbscu_pkg::PW_RST;
    localparam logic [MAX_WIDTH-1:0] RST_SREG =
        MAX_WIDTH'(((65'd1 << RST_W) - 65'd1) & 65'(cbscu_pkg::INIT_RST));

    logic [MAX_WIDTH-1:0]         r_sreg;
    logic [cbscu_pkg::BYTE_W-1:0] r_byte;
    logic                         r_out_valid;
    logic [cbscu_pkg::CRC_W-1:0]  r_crc;

    logic [MAX_WIDTH-1:0]         w_mask;
    logic [WW-1:0]                w_wm1;
    logic [cbscu_pkg::BYTE_W-1:0] w_norm;
    logic                         w_bit;
    logic                         w_top;
    logic                         w_fb;
    logic [MAX_WIDTH-1:0]         w_shifted;
    logic [MAX_WIDTH-1:0]         n_sreg_shift;
    logic [MAX_WIDTH-1:0]         n_sreg_load;
    logic [MAX_WIDTH-1:0]         w_final;
    logic [MAX_WIDTH-1:0]         w_rev;
    logic [WW-1:0]                w_shamt;
    logic [MAX_WIDTH-1:0]         w_crc;

    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            w_mask[i] = (i < int'(i_eff_w));
        end
        w_wm1 = i_eff_w - WW'(1);

        // byte normalized so the first bit to shift sits at bit 0
        for (int i = 0; i < cbscu_pkg::BYTE_W; i++) begin
            w_norm[i] = i_cfg.reflect_input ? i_data_byte[i]
                                            : i_data_byte[cbscu_pkg::BYTE_W-1-i];
        end

        unique case (i_cmd.src)
            cbscu_pkg::SRC_INPUT: w_bit = w_norm[0];
            cbscu_pkg::SRC_BYTE:  w_bit = r_byte[0];
            cbscu_pkg::SRC_ZERO:  w_bit = 1'b0;
            default:              w_bit = 1'b0;
        endcase

        // one crc step, direct or augmented
        w_top        = r_sreg[w_wm1[IW-1:0]];
        w_shifted    = {r_sreg[MAX_WIDTH-2:0], (i_cfg.direct_mode ? 1'b0 : w_bit)};
        w_fb         = i_cfg.direct_mode ? (w_top ^ w_bit) : w_top;
        n_sreg_shift = (w_shifted ^ (w_fb ? MAX_WIDTH'(i_cfg.polynomial) : '0)) & w_mask;
        n_sreg_load  = MAX_WIDTH'(i_cfg.initial_value) & w_mask;

        // finish: xor, mask, optional reflection over the active width
        w_final = (r_sreg ^ MAX_WIDTH'(i_cfg.output_xor)) & w_mask;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            w_rev[i] = w_final[MAX_WIDTH-1-i];
        end
        w_shamt = WW'(MAX_WIDTH) - i_eff_w;
        w_crc   = i_cfg.reflect_output ? (w_rev >> w_shamt) : w_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sreg <= RST_SREG;
        end else if (i_cmd.finish || i_cmd.reload) begin
            r_sreg <= n_sreg_load;
        end else if (i_cmd.shift) begin
            r_sreg <= n_sreg_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_byte <= w_norm >> 1;
        end else if (i_cmd.shift && (i_cmd.src == cbscu_pkg::SRC_BYTE)) begin
            r_byte <= r_byte >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_crc_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_crc <= cbscu_pkg::CRC_W'(w_crc);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_crc_ready;
    assign o_crc_valid    = r_out_valid;
    assign o_crc          = r_crc;

endmodule

### hw/rtl/configurable_bit_serial_crc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_bit_serial_crc_unit
// bit-serial crc engine for generator polynomials of 1 to 32 bits
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries message bytes: tdata holds data_byte and bit_count, tlast
//   marks the final byte. m_axis carries one finished crc per message.
//   the register port (i_cfg_we/idx/wdata) sets polynomial, width, initial
//   value, output xor, reflection, augmentation and method; write it only
//   while no message is in flight. a write to a mapped index reloads the
//   shift register in the cycle after the write, and s_axis_tready is low while it does.
// timing:
//   one message bit per cycle through a single shift register, while bytes keep
//   arriving and no crc waits in the finish step. a byte of n valid bits shifts
//   its first bit with its transfer and holds s_axis_tready low while the rest
//   shift. after the last byte, effective-width zero bits shift in if augmentation
//   is on, then the finish step builds the crc, which shows on m_axis the cycle after.
// reset and stall:
//   reset loads the default crc-32 settings and the shift register.
//   the output register lets the next message be taken while a crc waits;
//   a second crc waits in the finish step until m_axis_tready frees the slot.
// ----------------------------------------------------------------------------
`include "configurable_bit_serial_crc_unit_defines.svh"

module configurable_bit_serial_crc_unit #(
    parameter int MAX_WIDTH = cbscu_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // register write port
    input  logic                            i_cfg_we,
    input  logic [cbscu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbscu_pkg::CFG_W-1:0]     i_cfg_wdata,
    // message byte stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [7:0] data_byte, [11:8] bit_count
    input  logic                            s_axis_tlast,  // last byte of the message
    // crc stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cbscu_pkg::CRC_W-1:0]     m_axis_tdata   // [31:0] crc
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    cbscu_pkg::t_cfg r_cfg;
    logic            r_cfg_reload;   // reload in the cycle after the write lands
    logic [WW-1:0]   w_eff_w;

    cbscu_pkg::t_cmd w_cmd;
    cbscu_pkg::t_sts w_sts;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polynomial     <= cbscu_pkg::POLY_RST;
            r_cfg.poly_width     <= cbscu_pkg::PW_W'(cbscu_pkg::PW_RST);
            r_cfg.initial_value  <= cbscu_pkg::INIT_RST;
            r_cfg.output_xor     <= cbscu_pkg::OXOR_RST;
            r_cfg.reflect_input  <= cbscu_pkg::REFIN_RST;
            r_cfg.reflect_output <= cbscu_pkg::REFOUT_RST;
            r_cfg.zero_augment   <= cbscu_pkg::AUG_RST;
            r_cfg.direct_mode    <= cbscu_pkg::DIRECT_RST;
            r_cfg_reload         <= 1'b0;
        end else begin
            // unmapped index: ignored, no reload
            r_cfg_reload <= i_cfg_we && (i_cfg_idx <= cbscu_pkg::REG_DIRECT);
            if (i_cfg_we) begin
                unique case (cbscu_pkg::t_cfg_idx'(i_cfg_idx))
                    cbscu_pkg::REG_POLY:    r_cfg.polynomial     <= i_cfg_wdata;
                    cbscu_pkg::REG_WIDTH:   r_cfg.poly_width     <= i_cfg_wdata[cbscu_pkg::PW_W-1:0];
                    cbscu_pkg::REG_INIT:    r_cfg.initial_value  <= i_cfg_wdata;
                    cbscu_pkg::REG_OXOR:    r_cfg.output_xor     <= i_cfg_wdata;
                    cbscu_pkg::REG_REFIN:   r_cfg.reflect_input  <= i_cfg_wdata[0];
                    cbscu_pkg::REG_REFOUT:  r_cfg.reflect_output <= i_cfg_wdata[0];
                    cbscu_pkg::REG_AUGMENT: r_cfg.zero_augment   <= i_cfg_wdata[0];
                    cbscu_pkg::REG_DIRECT:  r_cfg.direct_mode    <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // effective width: zero acts as one, anything above MAX_WIDTH saturates
    always_comb begin
        if (r_cfg.poly_width == '0) begin
            w_eff_w = WW'(1);
        end else if (int'(r_cfg.poly_width) > MAX_WIDTH) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(r_cfg.poly_width);
        end
    end

    cbscu_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_count      (s_axis_tdata[11:8]),
        .i_last       (s_axis_tlast),
        .i_zero_aug   (r_cfg.zero_augment),
        .i_eff_w      (w_eff_w),
        .i_cfg_reload (r_cfg_reload),
        .i_sts        (w_sts),
        .o_ready      (s_axis_tready),
        .o_cmd        (w_cmd)
    );

    cbscu_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_eff_w     (w_eff_w),
        .i_cmd       (w_cmd),
        .i_data_byte (s_axis_tdata[7:0]),
        .o_sts       (w_sts),
        .o_crc_valid (m_axis_tvalid),
        .i_crc_ready (m_axis_tready),
        .o_crc       (m_axis_tdata)
    );

    // a last byte with two or more bits keeps the input closed next cycle
    `CBSCU_ASSERT_NEXT(a_last_multi_bit_blocks, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata[11:8] >= 4'd2), !s_axis_tready)
    // a middle byte of at most one bit leaves the input open
    `CBSCU_ASSERT_NEXT(a_short_byte_reopens, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tlast && (s_axis_tdata[11:8] <= 4'd1), s_axis_tready)
    // a new crc only comes out of the finish step, where input is closed
    `CBSCU_ASSERT_SAME(a_crc_from_finish, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

### verif/configurable_bit_serial_crc_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_bit_serial_crc_unit_tb
// self-checking bench: message bytes go in on s_axis and a scoreboard class
// predicts every crc from its own bit-serial model of the register; each crc
// on m_axis is matched against the oldest prediction. the register map is
// reprogrammed between messages across fixed corner settings and random ones
// ----------------------------------------------------------------------------
module configurable_bit_serial_crc_unit_tb;
    import cbscu_pkg::*;

    localparam int ITEM_GOAL      = 1450;  // random message bytes
    localparam int PHASE_ITEMS    = 110;   // bytes per register setting
    localparam int FIXED_SETTINGS = 7;
    localparam int SETTLE_CYCLES  = 64;    // one byte plus a full augment pass, with margin
    localparam int STALL_LIMIT    = 4000;  // cycles without any transfer
    localparam int MAX_REPORTS    = 20;

    typedef struct {
        logic [CFG_W-1:0] poly;
        logic [PW_W-1:0]  width;
        logic [CFG_W-1:0] init;
        logic [CFG_W-1:0] oxor;
        logic             refin;
        logic             refout;
        logic             aug;
        logic             direct;
    } crc_setting_t;

    // ------------------------------------------------------------------------
    // crc predictor and store of pending crc values
    // ------------------------------------------------------------------------
    class crc_scoreboard;
        logic [CFG_W-1:0] poly;
        logic [PW_W-1:0]  width;
        logic [CFG_W-1:0] init;
        logic [CFG_W-1:0] oxor;
        logic             refin;
        logic             refout;
        logic             aug;
        logic             direct;
        logic [63:0]      sreg;
        logic [CRC_W-1:0] crc_q [$];
        int               errors;
        int               crcs_checked;
        int               bytes_noted;

        function new();
            poly         = POLY_RST;
            width        = PW_W'(PW_RST);
            init         = INIT_RST;
            oxor         = OXOR_RST;
            refin        = REFIN_RST;
            refout       = REFOUT_RST;
            aug          = AUG_RST;
            direct       = DIRECT_RST;
            errors       = 0;
            crcs_checked = 0;
            bytes_noted  = 0;
            reload();
        endfunction

        // 0 acts as 1, anything above 32 saturates
        function int unsigned active_width();
            int unsigned w;
            w = width;
            if (w == 0) w = 1;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            return w;
        endfunction

        function logic [63:0] mask_of(int unsigned w);
            return (64'd1 << w) - 64'd1;
        endfunction

        function void reload();
            sreg = {32'd0, init} & mask_of(active_width());
        endfunction

        function int pending();
            return crc_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_POLY:    poly   = val;
                REG_WIDTH:   width  = val[PW_W-1:0];
                REG_INIT:    init   = val;
                REG_OXOR:    oxor   = val;
                REG_REFIN:   refin  = val[0];
                REG_REFOUT:  refout = val[0];
                REG_AUGMENT: aug    = val[0];
                REG_DIRECT:  direct = val[0];
                default:     return;  // outside the map: no effect, no reload
            endcase
            reload();
        endfunction

        function void shift_in(logic b, int unsigned w);
            logic top;
            logic fb;
            top = sreg[w-1];
            if (direct) begin
                fb   = top ^ b;
                sreg = sreg << 1;
            end else begin
                fb   = top;
                sreg = (sreg << 1) | {63'd0, b};
            end
            if (fb) sreg = sreg ^ {32'd0, poly};
            sreg = sreg & mask_of(w);
        endfunction

        function void note_byte(logic [BYTE_W-1:0] data, logic [CNT_W-1:0] cnt, logic last);
            int unsigned w;
            int unsigned n;
            logic [63:0] v;
            logic [63:0] r;
            w = active_width();
            n = (cnt > BITS_PER_BYTE) ? BYTE_W : cnt;
            bytes_noted++;
            for (int unsigned i = 0; i < n; i++)
                shift_in(refin ? data[i] : data[BYTE_W-1-i], w);
            if (!last) return;
            if (aug)
                for (int unsigned i = 0; i < w; i++)
                    shift_in(1'b0, w);
            v = (sreg ^ {32'd0, oxor}) & mask_of(w);
            r = v;
            if (refout) begin
                r = '0;
                for (int unsigned i = 0; i < w; i++)
                    r[i] = v[w-1-i];
            end
            crc_q.push_back(r[CRC_W-1:0]);
            reload();
        endfunction

        function void check_crc(logic [CRC_W-1:0] got);
            logic [CRC_W-1:0] want;
            if (crc_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: crc with no message pending, expected none, actual %h",
                             $time, got);
                return;
            end
            want = crc_q.pop_front();
            crcs_checked++;
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: crc mismatch, expected %h, actual %h", $time, want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and its ports
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = REG_POLY;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;   // [7:0] data_byte, [11:8] bit_count
    logic                 s_axis_tlast  = 1'b0; // last byte of the message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CRC_W-1:0]     m_axis_tdata;         // [31:0] crc

    crc_scoreboard sb = new();

    int send_idle_pct    = 9;
    int recv_idle_pct    = 86;
    int bytes_sent       = 0;
    int settings_applied = 0;
    int stall_cycles     = 0;

    configurable_bit_serial_crc_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // monitor: outputs are sampled at the edge, before the block updates them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // crc check first, a byte taken at this edge cannot finish here
            if (m_axis_tvalid && m_axis_tready)
                sb.check_crc(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata[7:0], s_axis_tdata[11:8], s_axis_tlast);
        end
        // crc receiver backpressure
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: any transfer or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one byte transfer on s_axis; returns at the edge that took it
    task automatic put_byte(input logic [BYTE_W-1:0] data, input logic [CNT_W-1:0] cnt,
                            input logic last);
        // idling plan: sender light then heavy, receiver the opposite, then none at all
        if (bytes_sent < ITEM_GOAL / 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 86;
        end else if (bytes_sent < 2 * ITEM_GOAL / 3) begin
            send_idle_pct = 86;
            recv_idle_pct = 9;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, cnt, data};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // wait for every crc, then let any tail shifting run out
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // every register once; narrow registers get junk in their unused bits
    task automatic apply_setting(input crc_setting_t s);
        logic [CFG_W-1:0] junk;
        junk = $urandom();
        cfg_put(REG_POLY, s.poly);
        cfg_put(REG_WIDTH, {junk[CFG_W-1:PW_W], s.width});
        cfg_put(REG_INIT, s.init);
        cfg_put(REG_OXOR, s.oxor);
        junk = $urandom();
        cfg_put(REG_REFIN, {junk[CFG_W-1:1], s.refin});
        junk = $urandom();
        cfg_put(REG_REFOUT, {junk[CFG_W-1:1], s.refout});
        junk = $urandom();
        cfg_put(REG_AUGMENT, {junk[CFG_W-1:1], s.aug});
        junk = $urandom();
        cfg_put(REG_DIRECT, {junk[CFG_W-1:1], s.direct});
        // index past the map, must be ignored
        cfg_put(CFG_IDX_W'($urandom_range(int'(REG_DIRECT) + 1, (1 << CFG_IDX_W) - 1)),
                $urandom());
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [CFG_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom());
        endcase
    endfunction

    // corner settings first: known crc, narrowest, widest, zero and oversized widths, reset settings
    function automatic crc_setting_t fixed_setting(int idx);
        crc_setting_t s;
        s.poly  = pick_word();
        s.width = PW_W'(PW_RST);
        s.init  = pick_word();
        s.oxor  = pick_word();
        {s.refin, s.refout, s.aug, s.direct} = 4'(($urandom()));
        case (idx)
            0: s = '{32'h0000_1021, 6'd16, 32'h0000_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1};
            1: s = '{32'h0000_0001, 6'd1, 32'h1, 32'h1, 1'b1, 1'b1, 1'b1, 1'b0};
            2: s = '{32'hFFFF_FFFF, 6'd32, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1, 1'b0};
            3: s = '{32'h0, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1};
            4: s = '{32'h0000_0007, 6'd63, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1};
            5: s.width = 6'd33;
            default: s = '{POLY_RST, PW_W'(PW_RST), INIT_RST, OXOR_RST,
                           REFIN_RST, REFOUT_RST, AUG_RST, DIRECT_RST};
        endcase
        return s;
    endfunction

    function automatic crc_setting_t random_setting();
        crc_setting_t s;
        s.poly   = pick_word();
        s.width  = ($urandom_range(0, 3) == 0) ? PW_W'($urandom_range(0, 63))
                                               : PW_W'($urandom_range(1, 32));
        s.init   = pick_word();
        s.oxor   = pick_word();
        s.refin  = 1'($urandom_range(0, 1));
        s.refout = 1'($urandom_range(0, 1));
        s.aug    = 1'($urandom_range(0, 1));
        s.direct = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // well-formed: full bytes, only the last one may be short; noisy: any count anywhere
    task automatic send_message(input int nbytes, input logic noisy);
        logic [CNT_W-1:0] cnt;
        for (int i = 0; i < nbytes; i++) begin
            if (noisy)
                cnt = CNT_W'($urandom_range(0, 15));
            else if (i == nbytes - 1)
                cnt = CNT_W'($urandom_range(1, 8));
            else
                cnt = BITS_PER_BYTE;
            put_byte(pick_byte(), cnt, i == nbytes - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        automatic int           phase = 0;
        automatic int           goal;
        automatic int           len;
        automatic crc_setting_t s;
        automatic logic [7:0]   check_str [9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                                                  8'h36, 8'h37, 8'h38, 8'h39};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings: standard check string, then bit count corners
        foreach (check_str[i])
            put_byte(check_str[i], BITS_PER_BYTE, i == 8);
        put_byte(8'h00, BITS_PER_BYTE, 1'b1);
        put_byte(8'hFF, BITS_PER_BYTE, 1'b1);
        put_byte(8'hA5, 4'd0, 1'b1);            // zero bit count still ends the message
        put_byte(8'h5A, 4'd1, 1'b1);
        put_byte(8'hC3, 4'd15, 1'b1);           // oversized counts act as a full byte
        put_byte(8'h3C, 4'd9, 1'b1);
        put_byte(8'hFF, 4'd0, 1'b0);
        put_byte(8'h81, 4'd7, 1'b1);

        // random part, one register setting per phase
        goal = bytes_sent + ITEM_GOAL;
        while (bytes_sent < goal) begin
            quiesce();
            s = (phase < FIXED_SETTINGS) ? fixed_setting(phase) : random_setting();
            apply_setting(s);
            for (int n = 0; n < PHASE_ITEMS && bytes_sent < goal; n += len) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
                                                  : $urandom_range(1, 4);
                send_message(len, $urandom_range(0, 99) < 15);
            end
            phase++;
        end

        quiesce();

        $display("covered %0d message bytes and %0d crc values over %0d register settings",
                 sb.bytes_noted, sb.crcs_checked, settings_applied);
        $display("widths 0 to 63, both bit orders, direct and augmented shifting, odd counts");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### configurable_bit_serial_crc_unit.f
+incdir+hw/rtl
hw/rtl/cbscu_pkg.sv
hw/rtl/cbscu_ctrl.sv
hw/rtl/cbscu_dp.sv
hw/rtl/configurable_bit_serial_crc_unit.sv
verif/configurable_bit_serial_crc_unit_tb.sv
